[design/elf64_image_load_checker_core_macros.svh]
// Assertion macros shared by the checker core.
// Depends on nothing; included by the top level only.
`ifndef ELF64_IMAGE_LOAD_CHECKER_CORE_MACROS_SVH
`define ELF64_IMAGE_LOAD_CHECKER_CORE_MACROS_SVH
// Same-cycle implication, held off during reset.
`define ELFLD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, held off during reset.
`define ELFLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

[design/elfld_pkg.sv]
// Types and constants of the image load checker.
// Depends on nothing; used by elfld_header_check and the core.
package elfld_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNCATED = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_CLASS     = 4'd3;
  localparam logic [3:0] ST_ENDIAN    = 4'd4;
  localparam logic [3:0] ST_TYPE      = 4'd5;
  localparam logic [3:0] ST_MACHINE   = 4'd6;
  localparam logic [3:0] ST_TABLE     = 4'd7;
  localparam logic [3:0] ST_SEGMENT   = 4'd8;
  localparam logic [3:0] ST_WRITER    = 4'd9;
  localparam logic [3:0] ST_NONE      = 4'd10;

  localparam logic [63:0] HEADER_BYTES = 64'd64;
  localparam logic [15:0] ENTRY_BYTES  = 16'd56;
  localparam logic [31:0] ELF_MAGIC    = 32'h464C_457F;
  localparam logic [15:0] MACHINE_X86_64 = 16'd62;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] image_bytes;
    logic [63:0] read_word;
    logic        writer_ok;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
    logic [63:0] source_offset;
    logic [63:0] file_bytes;
    logic [63:0] memory_bytes;
    logic [31:0] segment_flags;
    logic [3:0]  status;
    logic        no_load_segment;
    logic [63:0] entry_address;
  } out_t;

endpackage

[design/elfld_if.sv]
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from elfld_pkg.
interface elfld_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/elfld_header_check.sv]
// Checks the 64-byte file header once its last word arrives.
// Depends on elfld_pkg.
module elfld_header_check #(
  parameter int MAX_PROGRAM_HEADERS = 64
) (
  input  logic [63:0] w0,
  input  logic [63:0] w2,
  input  logic [63:0] w6,
  input  logic [63:0] w7,
  input  logic [63:0] phoff,
  input  logic [63:0] size_of_image,
  output logic [3:0]  status
);
  logic [15:0] n;
  logic [21:0] entry_span;
  logic [64:0] table_end;

  assign n          = w7[15:0];
  assign entry_span = 22'(n) * 22'(elfld_pkg::ENTRY_BYTES);
  assign table_end  = {1'b0, phoff} + 65'(entry_span);

  always_comb begin
    status = elfld_pkg::ST_OK;
    if (w0[31:0] != elfld_pkg::ELF_MAGIC) begin
      status = elfld_pkg::ST_MAGIC;
    end else if (w0[39:32] != 8'd2) begin
      status = elfld_pkg::ST_CLASS;
    end else if (w0[47:40] != 8'd1) begin
      status = elfld_pkg::ST_ENDIAN;
    end else if (w0[55:48] != 8'd1 || w2[63:32] != 32'd1) begin
      status = elfld_pkg::ST_MAGIC;
    end else if (w2[15:0] != 16'd2) begin
      status = elfld_pkg::ST_TYPE;
    end else if (w2[31:16] != elfld_pkg::MACHINE_X86_64) begin
      status = elfld_pkg::ST_MACHINE;
    end else if (w6[47:32] != elfld_pkg::HEADER_BYTES[15:0] ||
                 w6[63:48] != elfld_pkg::ENTRY_BYTES || n == 16'd0 ||
                 17'(n) > 17'(MAX_PROGRAM_HEADERS)) begin
      status = elfld_pkg::ST_TABLE;
    end else if (table_end[64] || table_end[63:0] > size_of_image) begin
      status = elfld_pkg::ST_TABLE;
    end
  end
endmodule

[design/elfld_entry_check.sv]
// Checks one loadable program header entry: sizes, overflow, alignment.
// Depends on nothing beyond its ports.
module elfld_entry_check (
  input  logic [63:0] offset,
  input  logic [63:0] vaddr,
  input  logic [63:0] file_size,
  input  logic [63:0] mem_size,
  input  logic [63:0] align,
  input  logic [63:0] size_of_image,
  output logic        bad
);
  logic [64:0] file_end;
  logic [64:0] mem_end;
  logic [63:0] align_mask;

  assign file_end   = {1'b0, offset} + {1'b0, file_size};
  assign mem_end    = {1'b0, vaddr} + {1'b0, mem_size};
  assign align_mask = align - 64'd1;

  always_comb begin
    bad = 1'b0;
    if (file_size > mem_size) bad = 1'b1;
    if (file_end[64] || file_end[63:0] > size_of_image) bad = 1'b1;
    if (mem_end[64]) bad = 1'b1;
    if (align != 64'd0 && (align & align_mask) != 64'd0) bad = 1'b1;
    if (align > 64'd1 && ((vaddr ^ offset) & align_mask) != 64'd0) bad = 1'b1;
  end
endmodule

[design/elf64_image_load_checker_core.sv]
// Load checker for a 64-bit little-endian x86-64 executable image. A start
// transaction gives the image size; the core then issues read requests by byte
// offset, takes the eight header words back, checks the header and walks the
// program header table, issuing a segment-write request for each loadable entry
// and waiting for its acknowledge, and ends with a finished result carrying
// status and entry address. Every input transaction is handled by the logic
// between the input handshake and the result register, so one transaction is
// taken per clock while the result register is free or being drained.
// Depends on elfld_pkg, elfld_if, elfld_header_check, elfld_entry_check and the
// macro header.
`include "elf64_image_load_checker_core_macros.svh"
module elf64_image_load_checker_core #(
  parameter int MAX_PROGRAM_HEADERS = 64
) (
  input  logic     clk,
  input  logic     rst,
  elfld_if.sink    in_ch,
  elfld_if.source  out_ch
);
  localparam int TIDX_W = $clog2(MAX_PROGRAM_HEADERS + 1);

  typedef enum logic [1:0] {IDLE, HEADER, ENTRY, WAIT_ACK} phase_t;

  // Control state.
  phase_t               phase, phase_next;
  logic [2:0]           word_index, word_index_next;
  logic [TIDX_W-1:0]    table_index, table_index_next;
  logic                 loaded, loaded_next;
  logic                 out_valid, out_valid_next;

  // Payload state; every stored word is written before it is read.
  logic [63:0]          size_of_image, size_of_image_next;
  logic [63:0]          entry_base, entry_base_next;
  logic [63:0]          header_words [8];
  logic [63:0]          entry_words [7];
  elfld_pkg::out_t      out_data;

  elfld_pkg::in_t       in_data;
  elfld_pkg::out_t      res;
  logic                 in_ready;
  logic                 in_fire;
  logic                 produce;
  logic [3:0]           hdr_status;
  logic                 entry_bad;
  logic                 last_entry;
  logic [63:0]          next_base;
  logic [3:0]           k_plus;

  assign in_data      = in_ch.data;
  // The result register frees up in the same cycle that its transaction leaves.
  assign in_ready     = !out_valid || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  elfld_header_check #(
    .MAX_PROGRAM_HEADERS(MAX_PROGRAM_HEADERS)
  ) u_header_check (
    .w0           (header_words[0]),
    .w2           (header_words[2]),
    .w6           (header_words[6]),
    .w7           (in_data.read_word),
    .phoff        (header_words[4]),
    .size_of_image(size_of_image),
    .status       (hdr_status)
  );

  // The alignment word is the last one of an entry and comes straight in.
  elfld_entry_check u_entry_check (
    .offset       (entry_words[1]),
    .vaddr        (entry_words[2]),
    .file_size    (entry_words[4]),
    .mem_size     (entry_words[5]),
    .align        (in_data.read_word),
    .size_of_image(size_of_image),
    .bad          (entry_bad)
  );

  // Table walking: the base offset of the current entry is kept in a register,
  // so moving to the next entry costs one add of the entry size.
  assign last_entry = (17'(table_index) + 17'd1) >= {1'b0, header_words[7][15:0]};
  assign next_base  = entry_base + 64'(elfld_pkg::ENTRY_BYTES);
  assign k_plus     = 4'(word_index) + 4'd1;

  always_comb begin
    phase_next         = phase;
    word_index_next    = word_index;
    table_index_next   = table_index;
    loaded_next        = loaded;
    size_of_image_next = size_of_image;
    entry_base_next    = entry_base;
    produce            = 1'b0;
    res                = '0;
    if (in_fire) begin
      case (in_data.operation)
        elfld_pkg::OP_START: begin
          // A start abandons whatever image was in progress.
          size_of_image_next = in_data.image_bytes;
          word_index_next    = 3'd0;
          table_index_next   = '0;
          loaded_next        = 1'b0;
          produce            = 1'b1;
          if (in_data.image_bytes < elfld_pkg::HEADER_BYTES) begin
            phase_next = IDLE;
            res.kind   = elfld_pkg::KIND_FINISH;
            res.status = elfld_pkg::ST_TRUNCATED;
          end else begin
            phase_next = HEADER;
            res.kind   = elfld_pkg::KIND_READ;
          end
        end
        elfld_pkg::OP_READ: begin
          if (phase == HEADER) begin
            produce = 1'b1;
            if (word_index != 3'd7) begin
              word_index_next = k_plus[2:0];
              res.kind        = elfld_pkg::KIND_READ;
              res.address     = 64'({k_plus, 3'b000});
            end else if (hdr_status != elfld_pkg::ST_OK) begin
              phase_next = IDLE;
              res.kind   = elfld_pkg::KIND_FINISH;
              res.status = hdr_status;
            end else begin
              phase_next       = ENTRY;
              word_index_next  = 3'd0;
              table_index_next = '0;
              loaded_next      = 1'b0;
              entry_base_next  = header_words[4];
              res.kind         = elfld_pkg::KIND_READ;
              res.address      = header_words[4];
            end
          end else if (phase == ENTRY) begin
            produce = 1'b1;
            if (word_index == 3'd0 && in_data.read_word[31:0] != 32'd1) begin
              // Not a loadable entry: skip the rest of it.
              if (last_entry) begin
                phase_next = IDLE;
                res.kind   = elfld_pkg::KIND_FINISH;
                if (loaded) begin
                  res.entry_address = header_words[3];
                end else begin
                  res.status          = elfld_pkg::ST_NONE;
                  res.no_load_segment = 1'b1;
                end
              end else begin
                table_index_next = table_index + TIDX_W'(1);
                entry_base_next  = next_base;
                word_index_next  = 3'd0;
                res.kind         = elfld_pkg::KIND_READ;
                res.address      = next_base;
              end
            end else if (word_index != 3'd6) begin
              word_index_next = k_plus[2:0];
              res.kind        = elfld_pkg::KIND_READ;
              res.address     = entry_base + 64'({k_plus, 3'b000});
            end else if (entry_bad) begin
              phase_next = IDLE;
              res.kind   = elfld_pkg::KIND_FINISH;
              res.status = elfld_pkg::ST_SEGMENT;
            end else begin
              phase_next        = WAIT_ACK;
              res.kind          = elfld_pkg::KIND_WRITE;
              res.address       = entry_words[2];
              res.source_offset = entry_words[1];
              res.file_bytes    = entry_words[4];
              res.memory_bytes  = entry_words[5];
              res.segment_flags = entry_words[0][63:32];
            end
          end
        end
        elfld_pkg::OP_ACK: begin
          if (phase == WAIT_ACK) begin
            produce = 1'b1;
            if (!in_data.writer_ok) begin
              phase_next = IDLE;
              res.kind   = elfld_pkg::KIND_FINISH;
              res.status = elfld_pkg::ST_WRITER;
            end else begin
              loaded_next = 1'b1;
              if (last_entry) begin
                phase_next        = IDLE;
                res.kind          = elfld_pkg::KIND_FINISH;
                res.entry_address = header_words[3];
              end else begin
                phase_next       = ENTRY;
                table_index_next = table_index + TIDX_W'(1);
                entry_base_next  = next_base;
                word_index_next  = 3'd0;
                res.kind         = elfld_pkg::KIND_READ;
                res.address      = next_base;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (produce) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= IDLE;
      word_index  <= 3'd0;
      table_index <= '0;
      loaded      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      word_index  <= word_index_next;
      table_index <= table_index_next;
      loaded      <= loaded_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_of_image <= 64'd0;
    end else begin
      size_of_image <= size_of_image_next;
    end
    entry_base <= entry_base_next;
    if (produce) begin
      out_data <= res;
    end
    if (in_fire && in_data.operation == elfld_pkg::OP_READ && phase == HEADER) begin
      header_words[word_index] <= in_data.read_word;
    end
    if (in_fire && in_data.operation == elfld_pkg::OP_READ && phase == ENTRY) begin
      entry_words[word_index] <= in_data.read_word;
    end
  end

  // An empty result register must never hold off the input side.
  `ELFLD_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  // Waiting for an acknowledge only ever follows a segment-write transaction.
  `ELFLD_ASSERT_NOW(a_wait_after_write, clk, rst, phase == WAIT_ACK,
    out_data.kind == elfld_pkg::KIND_WRITE)
  // A finished result always returns the core to idle.
  `ELFLD_ASSERT_NEXT(a_finish_idles, clk, rst,
    produce && res.kind == elfld_pkg::KIND_FINISH, phase == IDLE && out_valid)

endmodule
